FILE: rtl/echo_distance_median_filter_macros.svh
// assertion macros used by the checker file
`ifndef ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH
`define ECHO_DISTANCE_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define EDMF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define EDMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/edmf_pkg.sv
package edmf_pkg;

   // field widths
   localparam int CHAN_W     = 1;
   localparam int ECHO_W     = 16;
   localparam int ELAPSED_W  = 16;
   localparam int DIST_W     = 10;
   localparam int PULSE_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // channel count and the widest channel index it may need
   localparam int EDMF_CHANNELS = 2;
   localparam int CH_MAX_W      = 3;

   // five distances per channel
   localparam int SLOTS = 5;

   // reset values
   localparam logic [DIST_W-1:0]  SLOT_RESET     = 10'd200;
   localparam logic [DIST_W-1:0]  MAX_DIST_RESET = 10'd200;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd30000;

   // microseconds to centimeters: (echo * 1124) >> 16
   localparam int CM_MULT_W = 11;
   localparam int CM_SHIFT  = 16;
   localparam int PROD_W    = ECHO_W + CM_MULT_W;
   localparam int RAW_W     = PROD_W - CM_SHIFT;
   localparam logic [CM_MULT_W-1:0] CM_MULT = 11'd1124;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_DISTANCE = 1'b0,
      REG_MAX_PULSE_US = 1'b1
   } csr_index_type;

   // control handed along the row of cells
   typedef struct packed {
      logic                shift;
      logic [CH_MAX_W-1:0] ch;
   } cell_ctrl_type;

   // median of five: drop the smallest of four twice, then take a minimum
   function automatic logic [DIST_W-1:0] median5(
      input logic [DIST_W-1:0] a_i,
      input logic [DIST_W-1:0] b_i,
      input logic [DIST_W-1:0] c_i,
      input logic [DIST_W-1:0] d_i,
      input logic [DIST_W-1:0] e_i
   );
      logic [DIST_W-1:0] a, b, c, d, e, t;
      a = a_i;
      b = b_i;
      c = c_i;
      d = d_i;
      e = e_i;
      // order the pairs (a,b) and (c,d)
      if (a > b) begin
         t = a; a = b; b = t;
      end
      if (c > d) begin
         t = c; c = d; d = t;
      end
      // a or c is smallest of four; keep the smaller pair's partner in b
      if (a > c) begin
         t = b; b = d; d = t;
         c = a;
      end
      // a is dropped; pair (b,e) ordered
      if (b > e) begin
         t = b; b = e; e = t;
      end
      // drop the smaller of b and c along with its pair order
      if (b > c) begin
         c = b;
         t = e; e = d; d = t;
      end
      // remaining three are e, c, d with c <= d
      return (e < c) ? e : c;
   endfunction

endpackage

FILE: rtl/edmf_req_if.sv
interface edmf_req_if;
   logic                             valid;
   logic                             ready;
   logic [edmf_pkg::CHAN_W-1:0]      channel;
   logic [edmf_pkg::ECHO_W-1:0]      echo_us;
   logic [edmf_pkg::ELAPSED_W-1:0]   elapsed_us;

   modport source (output valid, output channel, output echo_us, output elapsed_us,
                   input ready);
   modport sink   (input valid, input channel, input echo_us, input elapsed_us,
                   output ready);
endinterface

FILE: rtl/edmf_rsp_if.sv
interface edmf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [edmf_pkg::DIST_W-1:0]  median_cm;
   logic                         stale;

   modport source (output valid, output median_cm, output stale, input ready);
   modport sink   (input valid, input median_cm, input stale, output ready);
endinterface

FILE: rtl/edmf_cell.sv
module edmf_cell #(
   parameter int CHANNELS = edmf_pkg::EDMF_CHANNELS,
   parameter int CH_W     = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  edmf_pkg::cell_ctrl_type       ctrl,
   input  logic [edmf_pkg::DIST_W-1:0]   shift_in,
   output logic [edmf_pkg::DIST_W-1:0]   shift_out
);

   logic [edmf_pkg::DIST_W-1:0] value_ff [CHANNELS];
   logic [CH_W-1:0]             sel;

   assign sel = ctrl.ch[CH_W-1:0];

   // one distance per channel; selected channel takes its left neighbor on shift
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (reset) begin
            value_ff[c] <= edmf_pkg::SLOT_RESET;
         end else if (ctrl.shift && (sel == CH_W'(c))) begin
            value_ff[c] <= shift_in;
         end
      end
   end

   // selected channel's value to the right neighbor
   assign shift_out = value_ff[sel];

endmodule

FILE: rtl/echo_distance_median_filter.sv
// Echo distance median filter, median of five per sensor channel.
// req_chan carries one echo measurement per transaction: channel, echo_us
// and elapsed_us. rsp_chan returns one transaction per request, in order:
// median_cm and stale. Both use valid/ready; a transfer happens when both are
// high at a rising clock edge.
// A measurement with elapsed_us above max_pulse_us is not stored and returns
// the channel's current median with stale set. Otherwise the echo is scaled
// to centimeters, clamped to max_distance and shifted into the channel's row
// of five cells, dropping the oldest distance.
// An item is registered in stage 1 (compare, multiply), stage 2 (snapshot)
// and stage 3 (median); one transaction per cycle is sustained while rsp_chan
// is ready. The row of cells is updated as an item leaves the multiply stage,
// so back-to-back items on the same channel see each other's writes.
// csr_we/csr_index/csr_wdata write max_distance (index 0) and max_pulse_us
// (index 1); write only while no transaction is in flight.
// Reset (synchronous) empties the pipeline, sets every cell to 200 cm and
// restores the register defaults. When rsp_chan stalls, the three stages
// fill up and req_chan.ready drops only once all of them hold an item.
module echo_distance_median_filter #(
   parameter int CHANNELS = edmf_pkg::EDMF_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   edmf_req_if.sink                           req_chan,
   edmf_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [edmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [edmf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DW   = edmf_pkg::DIST_W;
   localparam int NS   = edmf_pkg::SLOTS;

   // configuration registers
   logic [DW-1:0]                    max_distance_ff;
   logic [edmf_pkg::PULSE_W-1:0]     max_pulse_us_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= edmf_pkg::MAX_DIST_RESET;
         max_pulse_us_ff <= edmf_pkg::MAX_PULSE_RESET;
      end else if (csr_we) begin
         unique case (edmf_pkg::csr_index_type'(csr_index))
            edmf_pkg::REG_MAX_DISTANCE: max_distance_ff <= csr_wdata[DW-1:0];
            edmf_pkg::REG_MAX_PULSE_US: max_pulse_us_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;
   logic req_take, s1_move, s2_move;

   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;
   assign req_take = req_chan.valid && s1_ready;
   assign s1_move  = s1_valid_ff && s2_ready;
   assign s2_move  = s2_valid_ff && s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: timeout compare and scaling multiply
   logic [CH_W-1:0]               req_ch;
   logic [edmf_pkg::PROD_W-1:0]   prod;
   logic [CH_W-1:0]               s1_ch_ff;
   logic [edmf_pkg::RAW_W-1:0]    s1_raw_ff;
   logic                          s1_stale_ff;

   assign req_ch = (CHANNELS > 1) ? CH_W'(req_chan.channel) : '0;
   assign prod   = edmf_pkg::PROD_W'(req_chan.echo_us) * edmf_pkg::PROD_W'(edmf_pkg::CM_MULT);

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ch_ff    <= req_ch;
         s1_raw_ff   <= prod[edmf_pkg::PROD_W-1:edmf_pkg::CM_SHIFT];
         s1_stale_ff <= (req_chan.elapsed_us > max_pulse_us_ff);
      end
   end

   // clamp to max_distance
   logic [DW-1:0] clamped;

   assign clamped = (s1_raw_ff > edmf_pkg::RAW_W'(max_distance_ff)) ? max_distance_ff
                                                                     : s1_raw_ff[DW-1:0];

   // row of cells, shifted as a fresh measurement leaves stage 1
   edmf_pkg::cell_ctrl_type cell_ctrl;
   logic [DW-1:0]           cell_in  [NS];
   logic [DW-1:0]           cell_out [NS];

   assign cell_ctrl.shift = s1_move && !s1_stale_ff;
   assign cell_ctrl.ch    = edmf_pkg::CH_MAX_W'(s1_ch_ff);

   for (genvar k = 0; k < NS; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_in[k] = clamped;
      end else begin : g_body
         assign cell_in[k] = cell_out[k-1];
      end
      edmf_cell #(
         .CHANNELS (CHANNELS),
         .CH_W     (CH_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .shift_in  (cell_in[k]),
         .shift_out (cell_out[k])
      );
   end

   // stage 2: snapshot of the channel's five distances, after the update if any
   logic [DW-1:0] s2_snap_ff [NS];
   logic          s2_stale_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int k = 0; k < NS; k++) begin
            s2_snap_ff[k] <= s1_stale_ff ? cell_out[k] : cell_in[k];
         end
         s2_stale_ff <= s1_stale_ff;
      end
   end

   // stage 3: median network into the output register
   logic [DW-1:0] median_in;
   logic [DW-1:0] median_ff;
   logic          stale_ff;

   assign median_in = edmf_pkg::median5(s2_snap_ff[0], s2_snap_ff[1], s2_snap_ff[2],
                                        s2_snap_ff[3], s2_snap_ff[4]);

   always_ff @(posedge clock) begin
      if (s2_move) begin
         median_ff <= median_in;
         stale_ff  <= s2_stale_ff;
      end
   end

   assign rsp_chan.valid     = s3_valid_ff;
   assign rsp_chan.median_cm = median_ff;
   assign rsp_chan.stale     = stale_ff;

endmodule

FILE: rtl/edmf_checker.sv
`include "echo_distance_median_filter_macros.svh"

module edmf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [edmf_pkg::DIST_W-1:0]       rsp_median_cm,
   input logic                              rsp_stale
);

   // transactions accepted and not yet answered
   logic [2:0] count_ff;
   logic [2:0] count_in;

   assign count_in = count_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // stalled response holds
   `EDMF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_median_cm) && $stable(rsp_stale), "stalled response changed")

   // a free output lets a request in
   `EDMF_ASSERT_NOW(a_ready_flow, rsp_ready, req_ready, "request blocked with output free")

   // no response without a request in flight
   `EDMF_ASSERT_NOW(a_no_invent, rsp_valid, count_ff != 3'd0, "response without request")

   // at most three transactions in flight
   `EDMF_ASSERT_NOW(a_depth, 1'b1, count_ff <= 3'd3, "more than three in flight")

endmodule

bind echo_distance_median_filter edmf_checker u_edmf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_median_cm (rsp_chan.median_cm),
   .rsp_stale     (rsp_chan.stale)
);
